>>> rtl/sbo_pkg.sv
// Shared constants and types for the segment against box overlap test.
// Used by every module of the block; has no dependencies of its own.
`timescale 1ns / 1ps

package sbo_pkg;

  // Default coordinate width: signed Q16.16.
  localparam int COORD_WIDTH_DEF = 32;

  // Three spatial axes.
  localparam int NUM_AXES = 3;

  // Configuration index width and the width of the result tdata.
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_DATA_W = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_e;

endpackage

>>> rtl/sbo_prep.sv
// First compute stage: box extents, segment direction, its magnitude and the
// midpoint offset, all at twice the real scale. Depends on sbo_pkg.
`timescale 1ns / 1ps

module sbo_prep import sbo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          ld_i,
  input  logic signed [COORD_WIDTH-1:0] start_i [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] end_i   [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] bmin_i  [NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] bmax_i  [NUM_AXES],
  output logic signed [COORD_WIDTH:0]   ext_o   [NUM_AXES],
  output logic signed [COORD_WIDTH:0]   dir_o   [NUM_AXES],
  output logic        [COORD_WIDTH:0]   adir_o  [NUM_AXES],
  output logic signed [COORD_WIDTH+1:0] ofs_o   [NUM_AXES]
);

  localparam int EW = COORD_WIDTH + 1;
  localparam int VW = COORD_WIDTH + 2;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    logic signed [EW-1:0] ext_d, dir_d, ndir_d;
    logic        [EW-1:0] adir_d;
    logic signed [VW-1:0] ofs_d;
    logic signed [EW-1:0] ext_q, dir_q;
    logic        [EW-1:0] adir_q;
    logic signed [VW-1:0] ofs_q;

    // Extent and direction; the magnitude picks one of two parallel differences.
    assign ext_d  = EW'(bmax_i[i]) - EW'(bmin_i[i]);
    assign dir_d  = EW'(end_i[i]) - EW'(start_i[i]);
    assign ndir_d = EW'(start_i[i]) - EW'(end_i[i]);
    assign adir_d = dir_d[EW-1] ? $unsigned(ndir_d) : $unsigned(dir_d);

    // Segment midpoint minus box center, both doubled.
    assign ofs_d = VW'(end_i[i]) + VW'(start_i[i]) - VW'(bmax_i[i]) - VW'(bmin_i[i]);

    always_ff @(posedge clk_i) begin
      if (ld_i) begin
        ext_q  <= ext_d;
        dir_q  <= dir_d;
        adir_q <= adir_d;
        ofs_q  <= ofs_d;
      end
    end

    assign ext_o[i]  = ext_q;
    assign dir_o[i]  = dir_q;
    assign adir_o[i] = adir_q;
    assign ofs_o[i]  = ofs_q;
  end

endmodule

>>> rtl/sbo_prod.sv
// Second compute stage: the twelve products of the cross-axis tests and the
// face-test limits, one multiplier per product. Depends on sbo_pkg.
`timescale 1ns / 1ps

module sbo_prod import sbo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            ld_i,
  input  logic signed [COORD_WIDTH:0]     ext_i  [NUM_AXES],
  input  logic signed [COORD_WIDTH:0]     dir_i  [NUM_AXES],
  input  logic        [COORD_WIDTH:0]     adir_i [NUM_AXES],
  input  logic signed [COORD_WIDTH+1:0]   ofs_i  [NUM_AXES],
  output logic signed [2*COORD_WIDTH+2:0] pa_o   [NUM_AXES],
  output logic signed [2*COORD_WIDTH+2:0] pb_o   [NUM_AXES],
  output logic signed [2*COORD_WIDTH+2:0] qa_o   [NUM_AXES],
  output logic signed [2*COORD_WIDTH+2:0] qb_o   [NUM_AXES],
  output logic signed [COORD_WIDTH+2:0]   lim_o  [NUM_AXES],
  output logic signed [COORD_WIDTH+1:0]   ofs_o  [NUM_AXES]
);

  localparam int PW = 2 * COORD_WIDTH + 3;
  localparam int TW = COORD_WIDTH + 3;
  localparam int VW = COORD_WIDTH + 2;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    localparam int J = (i + 1) % NUM_AXES;
    localparam int K = (i + 2) % NUM_AXES;

    logic signed [PW-1:0] pa_d, pb_d, qa_d, qb_d;
    logic signed [TW-1:0] lim_d;
    logic signed [PW-1:0] pa_q, pb_q, qa_q, qb_q;
    logic signed [TW-1:0] lim_q;
    logic signed [VW-1:0] ofs_q;

    // Cross product component and its bound, each term exact at full width.
    assign pa_d = PW'(dir_i[J]) * PW'(ofs_i[K]);
    assign pb_d = PW'(dir_i[K]) * PW'(ofs_i[J]);
    assign qa_d = PW'(ext_i[J]) * PW'($signed({1'b0, adir_i[K]}));
    assign qb_d = PW'(ext_i[K]) * PW'($signed({1'b0, adir_i[J]}));

    // Face-axis bound: extent plus direction magnitude.
    assign lim_d = TW'(ext_i[i]) + TW'($signed({1'b0, adir_i[i]}));

    always_ff @(posedge clk_i) begin
      if (ld_i) begin
        pa_q  <= pa_d;
        pb_q  <= pb_d;
        qa_q  <= qa_d;
        qb_q  <= qb_d;
        lim_q <= lim_d;
        ofs_q <= ofs_i[i];
      end
    end

    assign pa_o[i]  = pa_q;
    assign pb_o[i]  = pb_q;
    assign qa_o[i]  = qa_q;
    assign qb_o[i]  = qb_q;
    assign lim_o[i] = lim_q;
    assign ofs_o[i] = ofs_q;
  end

endmodule

>>> rtl/sbo_reduce.sv
// Third compute stage: combines product pairs into cross components and
// their bounds, and settles the three face-axis tests. Depends on sbo_pkg.
`timescale 1ns / 1ps

module sbo_reduce import sbo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            ld_i,
  input  logic signed [2*COORD_WIDTH+2:0] pa_i   [NUM_AXES],
  input  logic signed [2*COORD_WIDTH+2:0] pb_i   [NUM_AXES],
  input  logic signed [2*COORD_WIDTH+2:0] qa_i   [NUM_AXES],
  input  logic signed [2*COORD_WIDTH+2:0] qb_i   [NUM_AXES],
  input  logic signed [COORD_WIDTH+2:0]   lim_i  [NUM_AXES],
  input  logic signed [COORD_WIDTH+1:0]   ofs_i  [NUM_AXES],
  output logic signed [2*COORD_WIDTH+3:0] crs_o  [NUM_AXES],
  output logic signed [2*COORD_WIDTH+3:0] bnd_o  [NUM_AXES],
  output logic                            face_sep_o
);

  localparam int RW = 2 * COORD_WIDTH + 4;
  localparam int FW = COORD_WIDTH + 4;

  logic [NUM_AXES-1:0] face_sep_d;
  logic                face_sep_q;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    logic signed [RW-1:0] crs_d, bnd_d, crs_q, bnd_q;
    logic signed [FW-1:0] lo_gap, hi_gap;

    assign crs_d = RW'(pa_i[i]) - RW'(pb_i[i]);
    assign bnd_d = RW'(qa_i[i]) + RW'(qb_i[i]);

    // |ofs| > lim exactly when lim - ofs or lim + ofs is negative.
    assign lo_gap        = FW'(lim_i[i]) - FW'(ofs_i[i]);
    assign hi_gap        = FW'(lim_i[i]) + FW'(ofs_i[i]);
    assign face_sep_d[i] = lo_gap[FW-1] | hi_gap[FW-1];

    always_ff @(posedge clk_i) begin
      if (ld_i) begin
        crs_q <= crs_d;
        bnd_q <= bnd_d;
      end
    end

    assign crs_o[i] = crs_q;
    assign bnd_o[i] = bnd_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      face_sep_q <= |face_sep_d;
    end
  end

  assign face_sep_o = face_sep_q;

endmodule

>>> rtl/sbo_decide.sv
// Last stage: cross-axis comparisons and the hit flag, held in the output
// register until the result transfer completes. Depends on sbo_pkg.
`timescale 1ns / 1ps

module sbo_decide import sbo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            ld_i,
  input  logic signed [2*COORD_WIDTH+3:0] crs_i [NUM_AXES],
  input  logic signed [2*COORD_WIDTH+3:0] bnd_i [NUM_AXES],
  input  logic                            face_sep_i,
  output logic                            hit_o
);

  localparam int CW2 = 2 * COORD_WIDTH + 5;

  logic [NUM_AXES-1:0] crs_sep;
  logic                hit_d, hit_q;

  // |cross| > bound exactly when bound - cross or bound + cross is negative.
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    logic signed [CW2-1:0] lo_gap, hi_gap;

    assign lo_gap     = CW2'(bnd_i[i]) - CW2'(crs_i[i]);
    assign hi_gap     = CW2'(bnd_i[i]) + CW2'(crs_i[i]);
    assign crs_sep[i] = lo_gap[CW2-1] | hi_gap[CW2-1];
  end

  // A hit needs every one of the six axes to overlap.
  assign hit_d = ~face_sep_i & ~(|crs_sep);

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

>>> rtl/segment_box_overlap_test.sv
// Segment against axis-aligned box overlap test, separating axis form.
// Five register stages: input, prep, products, reduce, output.
// Throughput: one segment per cycle unless the result side stalls; each
// stage is a set of parallel lanes, the widest being the twelve
// multipliers of the product stage.
// Reset clears the stage valids and the box registers to zero at once.
`timescale 1ns / 1ps

module segment_box_overlap_test import sbo_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // Configuration write port.
  input  logic                                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                         cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]                       cfg_wdata_i,
  // Segment input stream.
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // tdata from bit 0: seg_start_x, seg_start_y, seg_start_z,
  // seg_end_x, seg_end_y, seg_end_z, zero fill to whole bytes.
  input  logic [((2*NUM_AXES*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  // Result stream.
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // tdata from bit 0: hit, zero fill.
  output logic [OUT_DATA_W-1:0]                        m_axis_tdata
);

  localparam int CW = COORD_WIDTH;

  // Box corner registers.
  logic signed [CW-1:0] bmin_q [NUM_AXES];
  logic signed [CW-1:0] bmax_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        bmin_q[i] <= '0;
        bmax_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_X: bmin_q[0] <= cfg_wdata_i;
        REG_MIN_Y: bmin_q[1] <= cfg_wdata_i;
        REG_MIN_Z: bmin_q[2] <= cfg_wdata_i;
        REG_MAX_X: bmax_q[0] <= cfg_wdata_i;
        REG_MAX_Y: bmax_q[1] <= cfg_wdata_i;
        REG_MAX_Z: bmax_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when empty or when its content moves on.
  logic in_vld_q, prep_vld_q, prod_vld_q, red_vld_q, out_vld_q;
  logic ld_in, ld_prep, ld_prod, ld_red, ld_out;

  assign ld_out  = ~out_vld_q  | m_axis_tready;
  assign ld_red  = ~red_vld_q  | ld_out;
  assign ld_prod = ~prod_vld_q | ld_red;
  assign ld_prep = ~prep_vld_q | ld_prod;
  assign ld_in   = ~in_vld_q   | ld_prep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prep_vld_q <= 1'b0;
      prod_vld_q <= 1'b0;
      red_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (ld_in)   in_vld_q   <= s_axis_tvalid;
      if (ld_prep) prep_vld_q <= in_vld_q;
      if (ld_prod) prod_vld_q <= prep_vld_q;
      if (ld_red)  red_vld_q  <= prod_vld_q;
      if (ld_out)  out_vld_q  <= red_vld_q;
    end
  end

  // Input register: unpack the six coordinates.
  logic signed [CW-1:0] start_q [NUM_AXES];
  logic signed [CW-1:0] end_q   [NUM_AXES];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_in
    always_ff @(posedge clk_i) begin
      if (ld_in) begin
        start_q[i] <= s_axis_tdata[i*CW +: CW];
        end_q[i]   <= s_axis_tdata[(i+NUM_AXES)*CW +: CW];
      end
    end
  end

  logic signed [CW:0]     ext     [NUM_AXES];
  logic signed [CW:0]     dir     [NUM_AXES];
  logic        [CW:0]     adir    [NUM_AXES];
  logic signed [CW+1:0]   ofs_a   [NUM_AXES];
  logic signed [2*CW+2:0] pa      [NUM_AXES];
  logic signed [2*CW+2:0] pb      [NUM_AXES];
  logic signed [2*CW+2:0] qa      [NUM_AXES];
  logic signed [2*CW+2:0] qb      [NUM_AXES];
  logic signed [CW+2:0]   lim     [NUM_AXES];
  logic signed [CW+1:0]   ofs_b   [NUM_AXES];
  logic signed [2*CW+3:0] crs     [NUM_AXES];
  logic signed [2*CW+3:0] bnd     [NUM_AXES];
  logic                   face_sep;
  logic                   hit;

  sbo_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk_i   (clk_i),
    .ld_i    (ld_prep),
    .start_i (start_q),
    .end_i   (end_q),
    .bmin_i  (bmin_q),
    .bmax_i  (bmax_q),
    .ext_o   (ext),
    .dir_o   (dir),
    .adir_o  (adir),
    .ofs_o   (ofs_a)
  );

  sbo_prod #(.COORD_WIDTH(COORD_WIDTH)) u_prod (
    .clk_i  (clk_i),
    .ld_i   (ld_prod),
    .ext_i  (ext),
    .dir_i  (dir),
    .adir_i (adir),
    .ofs_i  (ofs_a),
    .pa_o   (pa),
    .pb_o   (pb),
    .qa_o   (qa),
    .qb_o   (qb),
    .lim_o  (lim),
    .ofs_o  (ofs_b)
  );

  sbo_reduce #(.COORD_WIDTH(COORD_WIDTH)) u_reduce (
    .clk_i      (clk_i),
    .ld_i       (ld_red),
    .pa_i       (pa),
    .pb_i       (pb),
    .qa_i       (qa),
    .qb_i       (qb),
    .lim_i      (lim),
    .ofs_i      (ofs_b),
    .crs_o      (crs),
    .bnd_o      (bnd),
    .face_sep_o (face_sep)
  );

  sbo_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
    .clk_i      (clk_i),
    .ld_i       (ld_out),
    .crs_i      (crs),
    .bnd_i      (bnd),
    .face_sep_i (face_sep),
    .hit_o      (hit)
  );

  assign s_axis_tready = ld_in;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, hit};

endmodule

>>> rtl/sbo_checker.sv
// Port-level checks for segment_box_overlap_test, attached by bind.
// Depends on sbo_pkg.
`timescale 1ns / 1ps

module sbo_checker import sbo_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The input side only backs up when the output is full and stalled.
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

  // Only the hit bit may be set in a result.
  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
    else $error("fill bits of the result are not zero");

  // No result may appear from an empty pipeline right after reset.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind segment_box_overlap_test sbo_checker u_sbo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/segment_box_overlap_test_tb.sv
// Self-checking testbench for segment_box_overlap_test: box registers are written
// through the config port, segments stream in, and each hit flag is checked.
// Depends on sbo_pkg and the block's RTL only.
`timescale 1ns / 1ps

module segment_box_overlap_test_tb import sbo_pkg::*;;

  localparam int COORD_W      = COORD_WIDTH_DEF;
  localparam int SEG_DATA_W   = ((2*NUM_AXES*COORD_W+7)/8)*8;
  localparam int HIT_BIT      = 0;
  localparam int PIPE_LATENCY = 4;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int CYCLE_LIMIT  = 200000;

  // Indexes past the last box register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  // Handy Q16.16 values.
  localparam logic signed [COORD_W-1:0] ONE     = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] TWO     = 32'sh0002_0000;
  localparam logic signed [COORD_W-1:0] TWO_HALF = 32'sh0002_8000;
  localparam logic signed [COORD_W-1:0] THREE   = 32'sh0003_0000;
  localparam logic signed [COORD_W-1:0] CMAX    = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] CMIN    = 32'sh8000_0000;
  localparam longint COORD_MIN_L = longint'(CMIN);
  localparam longint COORD_MAX_L = longint'(CMAX);

  // One segment, laid out as on s_axis_tdata (start_x in the lowest bits).
  typedef struct packed {
    logic signed [COORD_W-1:0] end_z;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_x;
  } segment_t;

  typedef struct packed {
    logic [31:0] seq;
    logic        hit;
  } hit_expect_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [COORD_W-1:0]    cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Fields from bit 0: seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z.
  logic [SEG_DATA_W-1:0] s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Fields from bit 0: hit, zero fill.
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the box registers, as the block should hold them.
  logic signed [COORD_W-1:0] box_lo [3] = '{default: '0};
  logic signed [COORD_W-1:0] box_hi [3] = '{default: '0};

  hit_expect_t expected_hits [$];
  int          error_count   = 0;
  int          items_sent    = 0;
  int          cycle_count   = 0;
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;

  segment_box_overlap_test #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [127:0] mag(input logic signed [127:0] x);
    return (x < 0) ? -x : x;
  endfunction

  // Separating axis test at double scale with full-width products, so it is exact.
  function automatic logic predict_hit(input segment_t seg);
    logic signed [127:0]       ext [3];
    logic signed [127:0]       dir [3];
    logic signed [127:0]       mid [3];
    logic signed [127:0]       st, en, lo, hi, cr, lim;
    logic signed [COORD_W-1:0] st_c [3];
    logic signed [COORD_W-1:0] en_c [3];
    logic                      hit;
    int                        j, k;
    st_c = '{seg.start_x, seg.start_y, seg.start_z};
    en_c = '{seg.end_x, seg.end_y, seg.end_z};
    hit  = 1'b1;
    // Box face axes.
    for (int a = 0; a < 3; a++) begin
      st = st_c[a];
      en = en_c[a];
      lo = box_lo[a];
      hi = box_hi[a];
      ext[a] = hi - lo;
      dir[a] = en - st;
      mid[a] = (en + st) - (hi + lo);
      if (mag(mid[a]) > ext[a] + mag(dir[a])) hit = 1'b0;
    end
    // Axes formed by the segment direction crossed with each box axis.
    for (int a = 0; a < 3; a++) begin
      j   = (a + 1) % 3;
      k   = (a + 2) % 3;
      cr  = dir[j] * mid[k] - dir[k] * mid[j];
      lim = ext[j] * mag(dir[k]) + ext[k] * mag(dir[j]);
      if (mag(cr) > lim) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic segment_t mk_seg(input logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez);
    return '{start_x: sx, start_y: sy, start_z: sz, end_x: ex, end_y: ey, end_z: ez};
  endfunction

  // Mostly coordinates around the current box, some on its faces, some anywhere.
  function automatic logic [COORD_W-1:0] pick_coord(input int axis);
    longint          lo, hi, base, span;
    longint unsigned rnd;
    int              sel;
    lo   = box_lo[axis];
    hi   = box_hi[axis];
    base = (lo < hi) ? lo : hi;
    span = ((lo < hi) ? hi - lo : lo - hi) + 2;
    sel  = $urandom_range(0, 99);
    rnd  = {$urandom(), $urandom()};
    if (sel < 10) return $urandom();
    if (sel < 25) begin
      case ($urandom_range(0, 3))
        0: return COORD_W'(lo);
        1: return COORD_W'(hi);
        2: return COORD_W'(lo - 1);
        default: return COORD_W'(hi + 1);
      endcase
    end
    return COORD_W'(base - span / 2 + longint'(rnd % longint'(2 * span + 1)));
  endfunction

  function automatic segment_t random_segment();
    logic [COORD_W-1:0] c [6];
    int                 kind;
    kind = $urandom_range(0, 99);
    for (int n = 0; n < 6; n++) c[n] = (kind < 8) ? $urandom() : pick_coord(n % 3);
    // Some segments collapse to a point.
    if (kind >= 8 && kind < 16) begin
      for (int n = 3; n < 6; n++) c[n] = c[n-3];
    end
    return mk_seg(c[0], c[1], c[2], c[3], c[4], c[5]);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // One register write; the caller lowers the write enable after its last write.
  task automatic write_box_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    case (idx)
      REG_MIN_X: box_lo[0] = value;
      REG_MIN_Y: box_lo[1] = value;
      REG_MIN_Z: box_lo[2] = value;
      REG_MAX_X: box_hi[0] = value;
      REG_MAX_Y: box_hi[1] = value;
      REG_MAX_Z: box_hi[2] = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_box(input logic signed [COORD_W-1:0] lx, ly, lz, hx, hy, hz);
    write_box_reg(REG_MIN_X, lx);
    write_box_reg(REG_MIN_Y, ly);
    write_box_reg(REG_MIN_Z, lz);
    write_box_reg(REG_MAX_X, hx);
    write_box_reg(REG_MAX_Y, hy);
    write_box_reg(REG_MAX_Z, hz);
    cfg_we_i = 1'b0;
  endtask

  // Offer one segment after a random gap and record its expected flag on transfer.
  task automatic send_segment(input segment_t seg);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = SEG_DATA_W'(seg);
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_hits.push_back('{seq: items_sent, hit: predict_hit(seg)});
    items_sent++;
    @(negedge clk_i);
  endtask

  // Wait until every expected flag is back, then let the pipeline settle.
  task automatic drain_results();
    int waited;
    waited        = 0;
    s_axis_tvalid = 1'b0;
    while (expected_hits.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_hits.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_hits.size()));
      expected_hits.delete();
    end
    repeat (PIPE_LATENCY + 2) @(negedge clk_i);
  endtask

  // Box from reset: all corners at the origin.
  task automatic test_reset_box();
    send_segment(mk_seg(0, 0, 0, 0, 0, 0));
    send_segment(mk_seg(ONE, 0, 0, ONE, 0, 0));
    send_segment(mk_seg(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_segment(mk_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    drain_results();
  endtask

  // Unit box: face hits and misses, boundary contact, points, and edge-axis misses.
  task automatic test_face_and_edge();
    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_segment(mk_seg(-TWO, -TWO, -TWO, TWO, TWO, TWO));
    send_segment(mk_seg(TWO, 0, 0, THREE, 0, 0));
    send_segment(mk_seg(0, -THREE, 0, 0, -TWO, 0));
    send_segment(mk_seg(0, 0, THREE, ONE, 0, THREE));
    send_segment(mk_seg(ONE, 0, 0, TWO, 0, 0));
    send_segment(mk_seg(-THREE, 0, 0, -ONE - 1, 0, 0));
    send_segment(mk_seg(0, 0, 0, 0, 0, 0));
    send_segment(mk_seg(ONE, ONE, ONE, ONE, ONE, ONE));
    send_segment(mk_seg(ONE, ONE, ONE + 1, ONE, ONE, ONE + 1));
    // Each of these clears the face axes but is split off by one cross axis.
    send_segment(mk_seg(0, TWO_HALF, 0, TWO_HALF, 0, 0));
    send_segment(mk_seg(0, 0, TWO_HALF, 0, TWO_HALF, 0));
    send_segment(mk_seg(TWO_HALF, 0, 0, 0, 0, TWO_HALF));
    // Grazes the box edge exactly.
    send_segment(mk_seg(0, TWO, 0, TWO, 0, 0));
    drain_results();
  endtask

  // Full-range box, inverted box, and a box collapsed onto the top corner.
  task automatic test_extreme_box();
    set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_segment(mk_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_segment(mk_seg(CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    send_segment(mk_seg(CMIN, CMAX, 0, CMAX, CMIN, 0));
    drain_results();
    set_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_segment(mk_seg(0, 0, 0, 0, 0, 0));
    send_segment(mk_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    drain_results();
    set_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_segment(mk_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    drain_results();
  endtask

  // Writes to the indexes past the box registers must leave the box alone.
  task automatic test_spare_index();
    write_box_reg(REG_UNUSED_A, $urandom());
    write_box_reg(REG_UNUSED_B, $urandom());
    cfg_we_i = 1'b0;
    send_segment(mk_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_segment(mk_seg(0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  // Random box per axis: sometimes flat, sometimes full range, sometimes inverted.
  task automatic pick_random_box();
    longint lo_l [3];
    longint hi_l [3];
    longint c, h, swap_v;
    int     sel, raw;
    for (int a = 0; a < 3; a++) begin
      sel = $urandom_range(0, 99);
      raw = $urandom();
      c   = raw >>> $urandom_range(0, 20);
      h   = longint'($urandom_range(0, 32'h7fff_ffff)) >> $urandom_range(0, 30);
      if (sel < 6) h = 0;
      lo_l[a] = c - h;
      hi_l[a] = c + h;
      if (lo_l[a] < COORD_MIN_L) lo_l[a] = COORD_MIN_L;
      if (hi_l[a] > COORD_MAX_L) hi_l[a] = COORD_MAX_L;
      if (sel >= 94) begin
        swap_v  = lo_l[a];
        lo_l[a] = hi_l[a];
        hi_l[a] = swap_v;
      end else if (sel >= 88) begin
        lo_l[a] = COORD_MIN_L;
        hi_l[a] = COORD_MAX_L;
      end
    end
    set_box(COORD_W'(lo_l[0]), COORD_W'(lo_l[1]), COORD_W'(lo_l[2]),
            COORD_W'(hi_l[0]), COORD_W'(hi_l[1]), COORD_W'(hi_l[2]));
  endtask

  // Blocks of random segments, each block against a fresh box.
  task automatic test_random_stream(input int item_total);
    int done_items, block_items;
    done_items = 0;
    while (done_items < item_total) begin
      pick_random_box();
      block_items = $urandom_range(30, 70);
      repeat (block_items) send_segment(random_segment());
      done_items += block_items;
      drain_results();
    end
  endtask

  // Result side back-pressure.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Compare every result transfer with the oldest expected flag.
  always @(posedge clk_i) begin : check_result
    hit_expect_t pending;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("hit=%0b with no segment pending", m_axis_tdata[HIT_BIT]));
      end else begin
        pending = expected_hits.pop_front();
        if (m_axis_tdata[HIT_BIT] !== pending.hit)
          report_mismatch($sformatf("segment %0d: hit=%0b, want %0b",
                                    pending.seq, m_axis_tdata[HIT_BIT], pending.hit));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 29;
    sink_idle_pct = 45;
    test_reset_box();
    test_face_and_edge();
    test_extreme_box();
    test_spare_index();
    test_random_stream(340);

    src_idle_pct  = 45;
    sink_idle_pct = 29;
    test_random_stream(340);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_stream(340);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> segment_box_overlap_test.f
rtl/sbo_pkg.sv
rtl/sbo_prep.sv
rtl/sbo_prod.sv
rtl/sbo_reduce.sv
rtl/sbo_decide.sv
rtl/segment_box_overlap_test.sv
rtl/sbo_checker.sv
tb/segment_box_overlap_test_tb.sv
